### hw/rtl/dspwm_pkg.sv
// ----------------------------------------------------------------------------
// dspwm_pkg
// Types and constants shared by the dual servo pulse generator.
// ----------------------------------------------------------------------------
package dspwm_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE     = 2'd3;

  // Configuration reset values
  localparam logic [7:0] SHORT_PULSE_RST  = 8'h01;
  localparam logic [7:0] LONG_PULSE_RST   = 8'h08;
  localparam logic [7:0] PULSE_PERIOD_RST = 8'h70;
  localparam logic [7:0] PRESCALE_RST     = 8'd50;

  // Item kinds carried on tuser
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Command codes
  localparam logic [7:0] CMD_FORWARD  = 8'h01;
  localparam logic [7:0] CMD_BACKWARD = 8'h02;
  localparam logic [7:0] CMD_LEFT     = 8'h03;
  localparam logic [7:0] CMD_RIGHT    = 8'h04;
  localparam logic [7:0] CMD_STOP     = 8'h05;
  localparam logic [7:0] CMD_RUN_TIME = 8'h07;

  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic [15:0] run_time;
    logic [7:0]  command_code;
    logic        opcode;
  } item_t;

  typedef struct packed {
    logic [7:0] short_pulse_len;
    logic [7:0] long_pulse_len;
    logic [7:0] pulse_period;
    logic [7:0] prescale_limit;
  } cfg_t;

endpackage

### hw/rtl/dspwm_cfg_regs.sv
// ----------------------------------------------------------------------------
// dspwm_cfg_regs
// Configuration register file: pulse lengths, period and prescaler limit.
// ----------------------------------------------------------------------------
module dspwm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dspwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_wdata,
  output dspwm_pkg::cfg_t                 cfg
);

  dspwm_pkg::cfg_t cfg_r;
  dspwm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        dspwm_pkg::REG_SHORT_PULSE:  cfg_nxt.short_pulse_len = cfg_wdata;
        dspwm_pkg::REG_LONG_PULSE:   cfg_nxt.long_pulse_len  = cfg_wdata;
        dspwm_pkg::REG_PULSE_PERIOD: cfg_nxt.pulse_period    = cfg_wdata;
        dspwm_pkg::REG_PRESCALE:     cfg_nxt.prescale_limit  = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_pulse_len <= dspwm_pkg::SHORT_PULSE_RST;
      cfg_r.long_pulse_len  <= dspwm_pkg::LONG_PULSE_RST;
      cfg_r.pulse_period    <= dspwm_pkg::PULSE_PERIOD_RST;
      cfg_r.prescale_limit  <= dspwm_pkg::PRESCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/dspwm_in_reg.sv
// ----------------------------------------------------------------------------
// dspwm_in_reg
// Input register stage: captures one item and holds it until the engine
// takes it.
// ----------------------------------------------------------------------------
module dspwm_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,
  input  logic                in_tuser,
  input  logic                take,
  output logic                item_valid,
  output dspwm_pkg::item_t    item
);

  logic             valid_r;
  logic             valid_nxt;
  dspwm_pkg::item_t item_r;
  logic             load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.opcode       <= in_tuser;
      item_r.command_code <= in_tdata[7:0];
      item_r.run_time     <= in_tdata[23:8];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### hw/rtl/dspwm_engine.sv
// ----------------------------------------------------------------------------
// dspwm_engine
// Servo drive state, pulse compare, phase and run-time counters, and the
// result register.
// ----------------------------------------------------------------------------
module dspwm_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dspwm_pkg::cfg_t                     cfg,
  input  logic                                item_valid,
  input  dspwm_pkg::item_t                    item,
  output logic                                take,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dspwm_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic        enabled_r,   enabled_nxt;
  logic        left_dir_r,  left_dir_nxt;
  logic        right_dir_r, right_dir_nxt;
  logic        timer_run_r, timer_run_nxt;
  logic [7:0]  left_phase_r,  left_phase_nxt;
  logic [7:0]  right_phase_r, right_phase_nxt;
  logic [7:0]  prescale_r,  prescale_nxt;
  logic [15:0] remain_r,    remain_nxt;
  logic        left_pin_r,  left_pin_nxt;
  logic        right_pin_r, right_pin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  left_thr;
  logic [7:0]  right_thr;
  logic [7:0]  left_inc;
  logic [7:0]  right_inc;

  assign take = item_valid && (!out_valid_r || out_tready);

  // Right side is mirrored: short pulse when its direction bit is clear
  assign left_thr  = left_dir_r  ? cfg.short_pulse_len : cfg.long_pulse_len;
  assign right_thr = right_dir_r ? cfg.long_pulse_len  : cfg.short_pulse_len;
  assign left_inc  = left_phase_r + 8'd1;
  assign right_inc = right_phase_r + 8'd1;

  always_comb begin
    enabled_nxt     = enabled_r;
    left_dir_nxt    = left_dir_r;
    right_dir_nxt   = right_dir_r;
    timer_run_nxt   = timer_run_r;
    left_phase_nxt  = left_phase_r;
    right_phase_nxt = right_phase_r;
    prescale_nxt    = prescale_r;
    remain_nxt      = remain_r;
    left_pin_nxt    = left_pin_r;
    right_pin_nxt   = right_pin_r;
    if (take) begin
      if (item.opcode == dspwm_pkg::OP_TICK) begin
        if (enabled_r) begin
          left_pin_nxt    = left_phase_r < left_thr;
          right_pin_nxt   = right_phase_r < right_thr;
          left_phase_nxt  = (left_inc == cfg.pulse_period) ? 8'd0 : left_inc;
          right_phase_nxt = (right_inc == cfg.pulse_period) ? 8'd0 : right_inc;
        end else begin
          left_pin_nxt  = 1'b0;
          right_pin_nxt = 1'b0;
        end
        if (prescale_r < cfg.prescale_limit) begin
          prescale_nxt = prescale_r + 8'd1;
        end else begin
          prescale_nxt = 8'd0;
          if (timer_run_r) begin
            if (remain_r != 16'd0) begin
              remain_nxt = remain_r - 16'd1;
            end else begin
              // Run time expired: stop the drive and drop both pins
              timer_run_nxt = 1'b0;
              enabled_nxt   = 1'b0;
              left_pin_nxt  = 1'b0;
              right_pin_nxt = 1'b0;
            end
          end
        end
      end else begin
        case (item.command_code)
          dspwm_pkg::CMD_FORWARD: begin
            enabled_nxt = 1'b1; left_dir_nxt = 1'b1; right_dir_nxt = 1'b1;
            timer_run_nxt = 1'b0;
          end
          dspwm_pkg::CMD_BACKWARD: begin
            enabled_nxt = 1'b1; left_dir_nxt = 1'b0; right_dir_nxt = 1'b0;
            timer_run_nxt = 1'b0;
          end
          dspwm_pkg::CMD_LEFT: begin
            enabled_nxt = 1'b1; left_dir_nxt = 1'b1; right_dir_nxt = 1'b0;
            timer_run_nxt = 1'b0;
          end
          dspwm_pkg::CMD_RIGHT: begin
            enabled_nxt = 1'b1; left_dir_nxt = 1'b0; right_dir_nxt = 1'b1;
            timer_run_nxt = 1'b0;
          end
          dspwm_pkg::CMD_STOP: begin
            enabled_nxt   = 1'b0;
            timer_run_nxt = 1'b0;
          end
          dspwm_pkg::CMD_RUN_TIME: begin
            remain_nxt    = item.run_time;
            timer_run_nxt = 1'b1;
          end
          default: begin
            enabled_nxt = enabled_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      left_dir_r    <= 1'b0;
      right_dir_r   <= 1'b0;
      timer_run_r   <= 1'b0;
      left_phase_r  <= 8'd0;
      right_phase_r <= 8'd0;
      prescale_r    <= 8'd0;
      remain_r      <= 16'd0;
      left_pin_r    <= 1'b1;
      right_pin_r   <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      enabled_r     <= enabled_nxt;
      left_dir_r    <= left_dir_nxt;
      right_dir_r   <= right_dir_nxt;
      timer_run_r   <= timer_run_nxt;
      left_phase_r  <= left_phase_nxt;
      right_phase_r <= right_phase_nxt;
      prescale_r    <= prescale_nxt;
      remain_r      <= remain_nxt;
      left_pin_r    <= left_pin_nxt;
      right_pin_r   <= right_pin_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  // Result flags follow the state registers, which change only when an item is taken
  assign out_tdata  = {4'b0000, timer_run_r, enabled_r, right_pin_r, left_pin_r};

endmodule

### hw/rtl/dual_servo_pwm_with_run_timer_core.sv
// ----------------------------------------------------------------------------
// dual_servo_pwm_with_run_timer_core
// Each accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while out_tready keeps up, set by the single
// state-update pass between the two registers. Reset (rst_n low, synchronous)
// clears drive and timer state, loads default pulse settings and sets both pins high.
// ----------------------------------------------------------------------------
module dual_servo_pwm_with_run_timer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // command_code[7:0], run_time[23:8]
  input  logic                            in_tuser,   // opcode[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // left_drive[0], right_drive[1],
                                                      // drive_enabled[2], timer_active[3]
  input  logic                            cfg_we,
  input  logic [dspwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_wdata
);

  dspwm_pkg::cfg_t  cfg;
  dspwm_pkg::item_t item;
  logic             item_valid;
  logic             take;

  dspwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dspwm_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dspwm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A held item with a stalled result must back-pressure the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are full");

  // Every item taken by the engine shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_tvalid)
    else $error("taken item produced no result");

  // Accepted input lands in the input register
  a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> item_valid)
    else $error("accepted item lost at input stage");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !item_valid))
    else $error("pipeline not empty after reset");

endmodule
